### design/u8dec_pkg.sv
// Package with the shared types, constants and lead-byte decode for the UTF-8 byte decoder.
package u8dec_pkg;

  localparam int unsigned CpWidth    = 31;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned ContBits   = 6;
  localparam logic [3:0]  MaxSeqLen  = 4'd6;

  typedef struct packed {
    logic                 valid;
    logic [ByteWidth-1:0] data;
  } byte_beat_t;

  typedef struct packed {
    logic out_stall;
    logic take;
  } flow_t;

  function automatic logic [3:0] lead_ones(input logic [ByteWidth-1:0] b);
    logic [3:0] n;
    priority casez (b)
      8'b0???????: n = 4'd0;
      8'b10??????: n = 4'd1;
      8'b110?????: n = 4'd2;
      8'b1110????: n = 4'd3;
      8'b11110???: n = 4'd4;
      8'b111110??: n = 4'd5;
      8'b1111110?: n = 4'd6;
      8'b11111110: n = 4'd7;
      default:     n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

### design/utf8_byte_decoder_core.sv
// Top level of the UTF-8 byte decoder: accepts one byte per beat and returns decoded code points.
//
// The block takes one byte of an original UTF-8 stream (sequences of one to six
// bytes) per clock while the output is not stalled and returns one code point for
// each completed character; bytes that open or continue a sequence give no result
// until the last one arrives. Lead bytes 0xFE and 0xFF give a result with malformed
// set and a zero code point. A byte passes through an input register and then the
// decode logic into the result register; with out_ready held high the block
// sustains one byte per cycle. The sequence state is updated as each byte leaves
// the input register.
module utf8_byte_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] code_point,
  output logic        malformed
);

  u8dec_pkg::byte_beat_t held;
  u8dec_pkg::flow_t      flow;

  u8dec_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .flow_in  (flow),
    .held     (held)
  );

  u8dec_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .held       (held),
    .flow_out   (flow),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .malformed  (malformed)
  );

endmodule

### design/u8dec_in_stage.sv
// Input register stage that holds one byte beat ahead of the decode stage.
module u8dec_in_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [u8dec_pkg::ByteWidth-1:0] in_byte,
  input  u8dec_pkg::flow_t              flow_in,
  output u8dec_pkg::byte_beat_t         held
);

  u8dec_pkg::byte_beat_t stage;

  assign in_ready = !stage.valid || !flow_in.out_stall;
  assign held     = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage.valid <= 1'b1;
    end else if (flow_in.take) begin
      stage.valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      stage.data <= in_byte;
    end
  end

endmodule

### design/u8dec_decode.sv
// Decode stage: sequence state, code point assembly and the result register.
module u8dec_decode (
  input  logic                           clk,
  input  logic                           rst,
  input  u8dec_pkg::byte_beat_t          held,
  output u8dec_pkg::flow_t               flow_out,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [u8dec_pkg::CpWidth-1:0]  code_point,
  output logic                           malformed
);

  logic [u8dec_pkg::CpWidth-1:0] accum_bits;
  logic [u8dec_pkg::CpWidth-1:0] accum_bits_next;
  logic [2:0]                    bytes_left;
  logic [2:0]                    bytes_left_next;
  logic                          emit;
  logic [u8dec_pkg::CpWidth-1:0] cp_result;
  logic                          bad_result;
  logic [3:0]                    n_ones;
  logic [u8dec_pkg::ByteWidth-1:0] lead_mask;
  logic                          out_stall;
  logic                          take;

  assign out_stall = out_valid && !out_ready;
  assign take      = held.valid && !out_stall;
  assign flow_out  = '{out_stall: out_stall, take: take};

  assign n_ones    = u8dec_pkg::lead_ones(held.data);
  assign lead_mask = 8'h7F >> n_ones;

  always_comb begin
    accum_bits_next = accum_bits;
    bytes_left_next = bytes_left;
    emit            = 1'b0;
    cp_result       = '0;
    bad_result      = 1'b0;
    if (bytes_left != 3'd0) begin
      accum_bits_next = {accum_bits[u8dec_pkg::CpWidth-u8dec_pkg::ContBits-1:0],
                         held.data[u8dec_pkg::ContBits-1:0]};
      bytes_left_next = bytes_left - 3'd1;
      if (bytes_left == 3'd1) begin
        emit            = 1'b1;
        cp_result       = accum_bits_next;
        accum_bits_next = '0;
      end
    end else if (n_ones <= 4'd1) begin
      emit      = 1'b1;
      cp_result = {{(u8dec_pkg::CpWidth-u8dec_pkg::ByteWidth){1'b0}}, held.data};
    end else if (n_ones > u8dec_pkg::MaxSeqLen) begin
      emit       = 1'b1;
      bad_result = 1'b1;
    end else begin
      accum_bits_next = {{(u8dec_pkg::CpWidth-u8dec_pkg::ByteWidth){1'b0}},
                         held.data & lead_mask};
      bytes_left_next = 3'(n_ones - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum_bits <= '0;
      bytes_left <= 3'd0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        accum_bits <= accum_bits_next;
        bytes_left <= bytes_left_next;
      end
      if (take && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      code_point <= cp_result;
      malformed  <= bad_result;
    end
  end

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the UTF-8 byte decoder core, with its own decode predictor.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [u8dec_pkg::CpWidth-1:0] code_point;
    logic                          malformed;
  } char_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_byte = 8'h00;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [u8dec_pkg::CpWidth-1:0] code_point;
  logic                          malformed;

  utf8_byte_decoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .malformed  (malformed)
  );

  // Predictor state: payload bits gathered so far and continuation bytes still owed.
  logic [u8dec_pkg::CpWidth-1:0] seq_payload = '0;
  logic [2:0]                    cont_owed = 3'd0;

  char_result_t expected_chars[$];
  char_result_t want_char;
  char_result_t got_char;
  char_result_t new_char;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned malformed_seen = 0;
  int unsigned multibyte_done = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timed out with %0d results outstanding", $time, expected_chars.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Works out the result, if any, that one accepted byte gives.
  function automatic bit decode_byte(input logic [7:0] b, output char_result_t r);
    int unsigned ones;
    ones = 0;
    r = '0;
    if (cont_owed != 3'd0) begin
      seq_payload = {seq_payload[u8dec_pkg::CpWidth-7:0], b[5:0]};
      cont_owed = cont_owed - 3'd1;
      if (cont_owed != 3'd0) return 1'b0;
      r.code_point = seq_payload;
      seq_payload = '0;
      multibyte_done++;
      return 1'b1;
    end
    while (ones < 8 && b[7 - ones]) ones++;
    if (ones <= 1) begin
      r.code_point = (u8dec_pkg::CpWidth)'(b);
      return 1'b1;
    end
    if (ones > 6) begin
      r.malformed = 1'b1;
      return 1'b1;
    end
    seq_payload = (u8dec_pkg::CpWidth)'(b & ((8'd1 << (7 - ones)) - 8'd1));
    cont_owed = 3'(ones - 1);
    return 1'b0;
  endfunction

  // Output beats are checked before the input beat of the same edge is predicted;
  // the block's latency keeps the two apart.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        got_char.code_point = code_point;
        got_char.malformed  = malformed;
        if (expected_chars.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, got code_point %h malformed %b",
                   $time, code_point, malformed);
        end else begin
          want_char = expected_chars.pop_front();
          chars_checked++;
          if (want_char.malformed) malformed_seen++;
          if (got_char.code_point !== want_char.code_point) begin
            error_count++;
            $display("%0t: code_point mismatch, expected %h, got %h",
                     $time, want_char.code_point, got_char.code_point);
          end
          if (got_char.malformed !== want_char.malformed) begin
            error_count++;
            $display("%0t: malformed mismatch, expected %b, got %b",
                     $time, want_char.malformed, got_char.malformed);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (decode_byte(in_byte, new_char)) expected_chars.push_back(new_char);
      end
    end
  end

  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= value;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  task automatic send_random_char();
    int unsigned kind;
    int unsigned len;
    logic [7:0]  lead;
    kind = $urandom_range(99);
    if (kind < 10) begin
      send_byte(8'($urandom_range(255)));
    end else if (kind < 14) begin
      send_byte(8'hFE | 8'($urandom_range(1)));
    end else begin
      len = $urandom_range(1, 6);
      if (len == 1) begin
        send_byte(8'($urandom_range(191)));
      end else begin
        lead = (8'hFF << (8 - len)) | (8'($urandom) & ((8'd1 << (7 - len)) - 8'd1));
        send_byte(lead);
        repeat (len - 1) begin
          if ($urandom_range(19) == 0) send_byte(8'($urandom_range(255)));
          else send_byte(8'h80 | 8'($urandom_range(63)));
        end
      end
    end
  endtask

  task automatic test_directed_bytes();
    logic [7:0] seq[$];
    send_idle_pct = 0;
    stall_pct = 0;
    // Single bytes at both ends, lone continuations and the two invalid lead bytes.
    seq = {8'h00, 8'h7F, 8'h80, 8'hBF, 8'hFE, 8'hFF};
    // Shortest and longest two-byte payloads, and longest three, four and six byte payloads.
    seq = {seq, 8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF};
    seq = {seq, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
    seq = {seq, 8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
    // A byte that looks like a lead byte is still taken as a continuation.
    seq = {seq, 8'hC3, 8'hFF};
    foreach (seq[i]) send_byte(seq[i]);
    wait_for_results();
  endtask

  task automatic test_pause_mid_sequence();
    send_idle_pct = 0;
    stall_pct = 25;
    send_byte(8'h41);
    send_byte(8'hFC);
    send_byte(8'h8A);
    send_byte(8'hB5);
    wait_for_results();
    send_byte(8'h80);
    send_byte(8'hBF);
    send_byte(8'h9C);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned hold_pct,
                                     input int unsigned n_bytes);
    int unsigned start;
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_random_char();
    wait_for_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_bytes();
    test_pause_mid_sequence();
    test_random_traffic(0, 0, 360);
    test_random_traffic(61, 0, 360);
    test_random_traffic(0, 61, 360);
    test_random_traffic(25, 25, 360);
    repeat (10) @(posedge clk);
    if (expected_chars.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_chars.size());
    end
    $display("Decoded %0d bytes into %0d checked results, %0d from multi-byte sequences,",
             bytes_sent, chars_checked, multibyte_done);
    $display("%0d flagged malformed, across phases with and without idling and stalls.",
             malformed_seen);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
